// File: src/fuel_level_event_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Fuel level event detector assertion macros
// Shared concurrent-assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FUEL_LEVEL_EVENT_DETECTOR_TOP_DEFINES_SVH
`define FUEL_LEVEL_EVENT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define FLED_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define FLED_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: src/fled_pkg.sv
// ----------------------------------------------------------------------------
// Fuel level event detector package
// Widths, register map, reset values and event codes.
// ----------------------------------------------------------------------------
package fled_pkg;

   localparam int AVG_DEPTH_DEFAULT = 5;

   localparam int SAMPLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int PERIOD_W  = 11;
   localparam int LEVEL_W   = 20;
   localparam int CODE_W    = 2;

   // divider: numerator below 2^31, quotient known to fit the level width
   localparam int NUM_W     = 31;
   localparam int QUO_W     = LEVEL_W;

   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_EMA_PERIOD       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FIX_WIDTH        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FIX_HOLD_MS      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REFUEL_THRESHOLD = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REFUEL_HYST      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DRAIN_THRESHOLD  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DRAIN_HYST       = 3'd6;

   localparam logic [PERIOD_W-1:0] RST_EMA_PERIOD       = 11'd50;
   localparam logic [CFG_W-1:0]    RST_FIX_WIDTH        = 16'd80;
   localparam logic [CFG_W-1:0]    RST_FIX_HOLD_MS      = 16'd5000;
   localparam logic [CFG_W-1:0]    RST_REFUEL_THRESHOLD = 16'd320;
   localparam logic [CFG_W-1:0]    RST_REFUEL_HYST      = 16'd160;
   localparam logic [CFG_W-1:0]    RST_DRAIN_THRESHOLD  = 16'd320;
   localparam logic [CFG_W-1:0]    RST_DRAIN_HYST       = 16'd160;

   localparam logic [CODE_W-1:0] EV_REFUEL_BEGIN  = 2'd0;
   localparam logic [CODE_W-1:0] EV_REFUEL_FINISH = 2'd1;
   localparam logic [CODE_W-1:0] EV_DRAIN_BEGIN   = 2'd2;
   localparam logic [CODE_W-1:0] EV_DRAIN_FINISH  = 2'd3;

endpackage

// File: src/fuel_level_event_detector_top.sv
// ----------------------------------------------------------------------------
// Fuel level event detector
// Ring mean, exponential filter, stability latch and refuel/drain detectors.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req       in   req_valid/req_ready  req_fuel_level, req_now_ms
//  rsp       out  rsp_valid/rsp_ready  rsp_event_code, rsp_begin_level, rsp_last_event
//  csr       in   APB write/read       csr_paddr, csr_pwdata, csr_prdata
//
// A sample passes the ring, mean, multiply, filter division, difference, stability
// and event states before the next is accepted: the ring mean is a multiply by a
// constant reciprocal, and the bit-serial divider performs the filter division by
// the period (skipped while the filter is still zero). req_ready is high only while
// the sequencer is idle; zero to two result words follow each sample and hold
// while rsp_ready is low. Synchronous reset clears the ring valid bits, all tracking
// state and the registers to defaults.
// ----------------------------------------------------------------------------
module fuel_level_event_detector_top #(
   parameter int AVG_DEPTH = fled_pkg::AVG_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fled_pkg::SAMPLE_W-1:0] req_fuel_level,
   input  logic [fled_pkg::TIME_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fled_pkg::CODE_W-1:0]   rsp_event_code,
   output logic [fled_pkg::LEVEL_W-1:0]  rsp_begin_level,
   output logic                          rsp_last_event,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fled_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [fled_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [fled_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import fled_pkg::*;

   localparam int SUM_W      = SAMPLE_W + $clog2(AVG_DEPTH);
   localparam int MEAN_NUM_W = SUM_W + 4;
   localparam int MEAN_SHIFT = MEAN_NUM_W + $clog2(AVG_DEPTH);
   localparam int RECIP_W    = MEAN_NUM_W + 1;
   localparam int MPROD_W    = MEAN_NUM_W + RECIP_W;
   // ceil(2^MEAN_SHIFT / AVG_DEPTH) gives the exact floor for every ring numerator
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

   typedef enum logic [3:0] {
      S_IDLE, S_RING, S_MEAN, S_MUL,
      S_FILT_GO, S_FILT_WAIT, S_DIFF, S_STAB, S_EVENT, S_EMIT
   } state_type;

   // configuration
   logic [PERIOD_W-1:0] cfg_period_ff;
   logic [CFG_W-1:0]    cfg_fix_width_ff;
   logic [CFG_W-1:0]    cfg_fix_hold_ff;
   logic [CFG_W-1:0]    cfg_refuel_thr_ff;
   logic [CFG_W-1:0]    cfg_refuel_hys_ff;
   logic [CFG_W-1:0]    cfg_drain_thr_ff;
   logic [CFG_W-1:0]    cfg_drain_hys_ff;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                csr_wr;

   // sequencer and tracking state
   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [LEVEL_W-1:0]  mean_ff, mean_in;
   logic [LEVEL_W-1:0]  filt_ff, filt_in;
   logic [NUM_W-1:0]    prod_ff, prod_in;
   logic signed [LEVEL_W:0] diff_ff, diff_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic                stable_ff, stable_in;
   logic [TIME_W-1:0]   last_unstable_ff, last_unstable_in;
   logic [LEVEL_W-1:0]  stable_level_ff, stable_level_in;
   logic                refuel_ff, refuel_in;
   logic                drain_ff, drain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0]   pend_code_ff, pend_code_in;
   logic [LEVEL_W-1:0]  pend_level_ff, pend_level_in;

   // datapath helpers
   logic                req_accept;
   logic [SUM_W-1:0]    ring_sum;
   logic [MPROD_W-1:0]  mean_prod;
   logic                div_start;
   logic [NUM_W-1:0]    div_numer;
   logic [PERIOD_W-1:0] div_denom;
   logic                div_done;
   logic [QUO_W-1:0]    div_quot;
   logic [PERIOD_W-1:0] period_eff;
   logic [PERIOD_W-1:0] period_m1;
   logic [LEVEL_W-1:0]  delta;
   logic [LEVEL_W-1:0]  win;
   logic signed [LEVEL_W+1:0] diff_x;
   logic signed [LEVEL_W+1:0] drop_x;
   logic signed [LEVEL_W+1:0] refuel_on;
   logic signed [LEVEL_W+1:0] drain_on;
   logic signed [CFG_W:0]     refuel_gap;
   logic signed [CFG_W:0]     drain_gap;
   logic signed [LEVEL_W+1:0] refuel_off;
   logic signed [LEVEL_W+1:0] drain_off;
   logic                refuel_begin, refuel_finish, drain_begin, drain_finish;

   assign req_accept = req_valid && req_ready;

   fled_ring #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept),
      .wr_data (req_fuel_level),
      .sum     (ring_sum)
   );

   // ring mean: (sum << 4) / AVG_DEPTH as a reciprocal multiply
   assign mean_prod = MPROD_W'({ring_sum, 4'b0000}) * MPROD_W'(MEAN_RECIP);

   assign period_eff = (cfg_period_ff == '0) ? PERIOD_W'(1) : cfg_period_ff;
   assign period_m1  = period_eff - 1'b1;

   assign div_start = (state_ff == S_FILT_GO);
   assign div_numer = prod_ff;
   assign div_denom = period_eff;

   fled_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // stability and detector terms
   assign delta = diff_ff[LEVEL_W] ? LEVEL_W'(-diff_ff) : LEVEL_W'(diff_ff);
   assign win   = {cfg_fix_width_ff, 4'b0000};

   assign diff_x     = {diff_ff[LEVEL_W], diff_ff};
   assign drop_x     = -diff_x;
   assign refuel_on  = $signed({2'b00, cfg_refuel_thr_ff, 4'b0000});
   assign drain_on   = $signed({2'b00, cfg_drain_thr_ff, 4'b0000});
   assign refuel_gap = $signed({1'b0, cfg_refuel_thr_ff}) - $signed({1'b0, cfg_refuel_hys_ff});
   assign drain_gap  = $signed({1'b0, cfg_drain_thr_ff}) - $signed({1'b0, cfg_drain_hys_ff});
   assign refuel_off = {refuel_gap[CFG_W], refuel_gap, 4'b0000};
   assign drain_off  = {drain_gap[CFG_W], drain_gap, 4'b0000};

   assign refuel_begin  = (diff_x >= refuel_on) && !refuel_ff;
   assign refuel_finish = (diff_x < refuel_off) && refuel_ff;
   assign drain_begin   = (drop_x >= drain_on) && !drain_ff;
   assign drain_finish  = (drop_x < drain_off) && drain_ff;

   always_comb begin
      state_in         = state_ff;
      now_in           = now_ff;
      mean_in          = mean_ff;
      filt_in          = filt_ff;
      prod_in          = prod_ff;
      diff_in          = diff_ff;
      elapsed_in       = elapsed_ff;
      stable_in        = stable_ff;
      last_unstable_in = last_unstable_ff;
      stable_level_in  = stable_level_ff;
      refuel_in        = refuel_ff;
      drain_in         = drain_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_last_in      = rsp_last_ff;
      pend_valid_in    = pend_valid_ff;
      pend_code_in     = pend_code_ff;
      pend_level_in    = pend_level_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_ms;
               state_in = S_RING;
            end
         end
         S_RING: begin
            state_in = S_MEAN;
         end
         S_MEAN: begin
            mean_in  = mean_prod[MEAN_SHIFT +: LEVEL_W];
            state_in = S_MUL;
         end
         S_MUL: begin
            if (filt_ff == '0) begin
               filt_in  = mean_ff;
               state_in = S_DIFF;
            end else begin
               prod_in  = NUM_W'(filt_ff) * NUM_W'(period_m1) + NUM_W'(mean_ff);
               state_in = S_FILT_GO;
            end
         end
         S_FILT_GO: begin
            state_in = S_FILT_WAIT;
         end
         S_FILT_WAIT: begin
            if (div_done) begin
               filt_in  = div_quot;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in    = $signed({1'b0, mean_ff}) - $signed({1'b0, filt_ff});
            elapsed_in = now_ff - last_unstable_ff;
            state_in   = S_STAB;
         end
         S_STAB: begin
            if (delta < win) begin
               if (!stable_ff && (elapsed_ff > TIME_W'(cfg_fix_hold_ff))) begin
                  stable_in = 1'b1;
                  if (!refuel_ff) begin
                     stable_level_in = mean_ff;
                  end
               end
            end else begin
               last_unstable_in = now_ff;
               if ({1'b0, delta} > {win, 1'b0}) begin
                  stable_in = 1'b0;
               end
            end
            state_in = S_EVENT;
         end
         S_EVENT: begin
            if (refuel_begin) begin
               refuel_in = 1'b1;
            end else if (refuel_finish) begin
               refuel_in = 1'b0;
            end
            if (drain_begin) begin
               drain_in = 1'b1;
            end else if (drain_finish) begin
               drain_in = 1'b0;
            end
            // refuel word goes first, the drain word waits behind it
            pend_code_in  = drain_begin ? EV_DRAIN_BEGIN : EV_DRAIN_FINISH;
            pend_level_in = drain_begin ? filt_ff : '0;
            if (refuel_begin || refuel_finish) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = refuel_begin ? EV_REFUEL_BEGIN : EV_REFUEL_FINISH;
               rsp_level_in  = refuel_begin ? stable_level_ff : '0;
               rsp_last_in   = !(drain_begin || drain_finish);
               pend_valid_in = drain_begin || drain_finish;
               state_in      = S_EMIT;
            end else if (drain_begin || drain_finish) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = pend_code_in;
               rsp_level_in  = pend_level_in;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (pend_valid_ff) begin
                  rsp_code_in   = pend_code_ff;
                  rsp_level_in  = pend_level_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         filt_ff          <= '0;
         stable_ff        <= 1'b0;
         last_unstable_ff <= '0;
         stable_level_ff  <= '0;
         refuel_ff        <= 1'b0;
         drain_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         filt_ff          <= filt_in;
         stable_ff        <= stable_in;
         last_unstable_ff <= last_unstable_in;
         stable_level_ff  <= stable_level_in;
         refuel_ff        <= refuel_in;
         drain_ff         <= drain_in;
         rsp_valid_ff     <= rsp_valid_in;
         pend_valid_ff    <= pend_valid_in;
      end
      now_ff        <= now_in;
      mean_ff       <= mean_in;
      prod_ff       <= prod_in;
      diff_ff       <= diff_in;
      elapsed_ff    <= elapsed_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
      pend_code_ff  <= pend_code_in;
      pend_level_ff <= pend_level_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_code  = rsp_code_ff;
   assign rsp_begin_level = rsp_level_ff;
   assign rsp_last_event  = rsp_last_ff;

   // register port
   assign csr_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_period_ff     <= RST_EMA_PERIOD;
         cfg_fix_width_ff  <= RST_FIX_WIDTH;
         cfg_fix_hold_ff   <= RST_FIX_HOLD_MS;
         cfg_refuel_thr_ff <= RST_REFUEL_THRESHOLD;
         cfg_refuel_hys_ff <= RST_REFUEL_HYST;
         cfg_drain_thr_ff  <= RST_DRAIN_THRESHOLD;
         cfg_drain_hys_ff  <= RST_DRAIN_HYST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_EMA_PERIOD:       cfg_period_ff     <= csr_pwdata[PERIOD_W-1:0];
            REG_FIX_WIDTH:        cfg_fix_width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_FIX_HOLD_MS:      cfg_fix_hold_ff   <= csr_pwdata[CFG_W-1:0];
            REG_REFUEL_THRESHOLD: cfg_refuel_thr_ff <= csr_pwdata[CFG_W-1:0];
            REG_REFUEL_HYST:      cfg_refuel_hys_ff <= csr_pwdata[CFG_W-1:0];
            REG_DRAIN_THRESHOLD:  cfg_drain_thr_ff  <= csr_pwdata[CFG_W-1:0];
            REG_DRAIN_HYST:       cfg_drain_hys_ff  <= csr_pwdata[CFG_W-1:0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_EMA_PERIOD:       csr_prdata = DATA_W'(cfg_period_ff);
         REG_FIX_WIDTH:        csr_prdata = DATA_W'(cfg_fix_width_ff);
         REG_FIX_HOLD_MS:      csr_prdata = DATA_W'(cfg_fix_hold_ff);
         REG_REFUEL_THRESHOLD: csr_prdata = DATA_W'(cfg_refuel_thr_ff);
         REG_REFUEL_HYST:      csr_prdata = DATA_W'(cfg_refuel_hys_ff);
         REG_DRAIN_THRESHOLD:  csr_prdata = DATA_W'(cfg_drain_thr_ff);
         REG_DRAIN_HYST:       csr_prdata = DATA_W'(cfg_drain_hys_ff);
         default:              csr_prdata = '0;
      endcase
   end

endmodule

// File: src/fled_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; the quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module fled_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fled_pkg::NUM_W-1:0]    numer,
   input  logic [fled_pkg::PERIOD_W-1:0] denom,
   output logic                          done,
   output logic [fled_pkg::QUO_W-1:0]    quot
);
   import fled_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [PERIOD_W-1:0] den_ff, den_in;

   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   trial_sub;
   logic                trial_ge;

   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         // remainder starts below the divisor since the quotient fits
         rem_in  = numer[NUM_W-1:QUO_W];
         quo_in  = numer[QUO_W-1:0];
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: src/fled_ring.sv
// ----------------------------------------------------------------------------
// Sample ring with running sum
// Replaces the oldest sample and keeps the sum of the ring up to date.
// ----------------------------------------------------------------------------
module fled_ring #(
   parameter  int AVG_DEPTH = fled_pkg::AVG_DEPTH_DEFAULT,
   localparam int SUM_W     = fled_pkg::SAMPLE_W + $clog2(AVG_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [fled_pkg::SAMPLE_W-1:0] wr_data,
   output logic [SUM_W-1:0]              sum
);
   import fled_pkg::*;

   localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

   logic [SAMPLE_W-1:0]  mem [AVG_DEPTH];
   logic [AVG_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 upd_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SAMPLE_W-1:0]  old_ff;
   logic [SAMPLE_W-1:0]  new_ff;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      if (wr_en) begin
         valid_in[idx_ff] = 1'b1;
         idx_in = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
      end
      if (upd_ff) begin
         sum_in = sum_ff + SUM_W'(new_ff) - SUM_W'(old_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idx_ff   <= '0;
         upd_ff   <= 1'b0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         upd_ff   <= wr_en;
         sum_ff   <= sum_in;
      end
   end

   // read the outgoing sample before it is overwritten; unwritten entries read zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         old_ff      <= valid_ff[idx_ff] ? mem[idx_ff] : '0;
         mem[idx_ff] <= wr_data;
         new_ff      <= wr_data;
      end
   end

   assign sum = sum_ff;

endmodule

// File: src/fled_checker.sv
// ----------------------------------------------------------------------------
// Fuel level event detector port checker
// Watches the top-level ports for sequencing and result-word rules.
// ----------------------------------------------------------------------------
`include "fuel_level_event_detector_top_defines.svh"

module fled_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fled_pkg::CODE_W-1:0]   rsp_event_code,
   input logic [fled_pkg::LEVEL_W-1:0]  rsp_begin_level,
   input logic                          rsp_last_event
);
   import fled_pkg::*;

   logic finish_word;

   assign finish_word = rsp_valid &&
                        (rsp_event_code == EV_REFUEL_FINISH || rsp_event_code == EV_DRAIN_FINISH);

   // no new sample while result words are pending
   `FLED_ASSERT_NOW(a_busy_while_rsp, rsp_valid, !req_ready, "sample accepted during results")

   // a sample keeps the block busy for at least the next cycle
   `FLED_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
                     "ready right after sample")

   // finish words carry no level
   `FLED_ASSERT_NOW(a_finish_zero, finish_word, rsp_begin_level == '0,
                    "finish word with nonzero level")

   // a word not marked last is followed at once by the next one
   `FLED_ASSERT_NEXT(a_second_word, rsp_valid && rsp_ready && !rsp_last_event, rsp_valid,
                     "missing second word")

   // a stalled word holds
   `FLED_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_event_code) && $stable(rsp_begin_level),
                     "stalled word changed")

endmodule

bind fuel_level_event_detector_top fled_checker u_fled_checker (.*);
